// ===== hw/rtl/aes_pkg.sv =====
// AES package: S-box tables and GF(2^8) helpers for the round pipeline.
// Used by aes_round and aes_block_cipher_enc_dec.
`default_nettype none
package aes_pkg;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ENC  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;
    localparam int unsigned MIN_ROUNDS = 10;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = x[7] ? ((x << 1) ^ 8'h1b) : (x << 1);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] a;
        acc = 8'h00;
        a = x;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) acc = acc ^ a;
            a = xt(a);
        end
        gmul = acc;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // byte k of a block sits at bits [127-8k -: 8]
    function automatic logic [7:0] get_byte(input t_block b, input int k);
        get_byte = b[127 - 8*k -: 8];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes_round.sv =====
// AES round stage: one registered cipher round (enc or dec) with stall hold.
// Depends on aes_pkg.
`default_nettype none
module aes_round (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic           i_dec,
    input  wire logic           i_bypass,
    input  wire logic           i_last,
    input  wire aes_pkg::t_block i_state,
    input  wire aes_pkg::t_block i_key,
    output logic                o_valid,
    output logic                o_dec,
    output aes_pkg::t_block     o_state
);
    import aes_pkg::*;

    t_block n_state;
    t_block w_sr;
    t_block w_sb;
    t_block w_mc;
    t_block w_ak;
    logic   r_valid;
    logic   r_dec;
    t_block r_state;

    // combine shift, substitute, mix and key add for one round
    always_comb begin
        logic [7:0] a0, a1, a2, a3;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_dec)
                    w_sr[127 - 8*(r + 4*((c + r) & 3)) -: 8] = get_byte(i_state, r + 4*c);
                else
                    w_sr[127 - 8*(r + 4*c) -: 8] = get_byte(i_state, r + 4*((c + r) & 3));
            end
        end
        for (int k = 0; k < 16; k++) begin
            w_sb[127 - 8*k -: 8] = i_dec ? ISBOX[get_byte(w_sr, k)] : SBOX[get_byte(w_sr, k)];
        end
        // enc mixes before key add; dec adds key then mixes
        w_ak = i_dec ? (w_sb ^ i_key) : w_sb;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a0 = get_byte(w_ak, 4*c + r);
                a1 = get_byte(w_ak, 4*c + ((r + 1) & 3));
                a2 = get_byte(w_ak, 4*c + ((r + 2) & 3));
                a3 = get_byte(w_ak, 4*c + ((r + 3) & 3));
                if (i_dec)
                    w_mc[127 - 8*(4*c + r) -: 8] = gmul(8'h0e, a0) ^ gmul(8'h0b, a1)
                                                 ^ gmul(8'h0d, a2) ^ gmul(8'h09, a3);
                else
                    w_mc[127 - 8*(4*c + r) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            end
        end
        if (i_bypass)
            n_state = i_state;
        else if (i_last)
            n_state = w_sb ^ i_key;
        else if (i_dec)
            n_state = w_mc;
        else
            n_state = w_mc ^ i_key;
    end

    // advance when the pipeline moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec   <= i_dec;
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
    assign o_state = r_state;
endmodule
`default_nettype wire

// ===== hw/rtl/aes_block_cipher_enc_dec.sv =====
// AES encrypt/decrypt engine top: key store, round pipeline, output register.
// Depends on aes_pkg and aes_round.
//
//  channel | signals                                   | role
//  in      | i_valid/o_ready, mode,slot,key,data       | block or key half
//  out     | o_valid/i_ready, result_high/low,was_dec  | one per cipher block
//  cfg     | i_cfg_we, i_cfg_data                      | round count
//
// One block enters per cycle unless the output stalls or a key load waits. The
// pipeline has MAX_ROUNDS+1 register stages: the entry register with the
// initial key add and one stage per round (rounds past the programmed count
// pass through); the last round stage drives the outputs. Synchronous reset
// clears valid bits and sets the round count to MIN_ROUNDS; the key store is
// undefined until loaded. A stall at the output freezes the whole pipeline;
// nothing is lost. A key load into a real slot waits for an empty pipeline.
`default_nettype none
module aes_block_cipher_enc_dec #(
    parameter int MAX_ROUNDS = 14
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [4:0]  i_key_slot,
    input  wire logic [63:0] i_key_half,
    input  wire logic [63:0] i_data_high,
    input  wire logic [63:0] i_data_low,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low,
    output logic             o_was_decrypt,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data
);
    import aes_pkg::*;

    localparam int SLOTS = (MAX_ROUNDS + 1) * 2;
    localparam int NR    = MAX_ROUNDS + 1;

    logic [63:0] r_keys [SLOTS];
    logic [3:0]  r_round_count;
    logic [3:0]  w_nr;
    logic        w_en;
    logic        w_cipher;
    logic        w_busy;
    logic        w_key_wait;

    logic        v_valid [NR];
    logic        v_dec   [NR];
    t_block      v_state [NR];

    // clamp round count into legal range
    always_comb begin
        if (r_round_count < 4'(MIN_ROUNDS))
            w_nr = 4'(MIN_ROUNDS);
        else if (r_round_count > 4'(MAX_ROUNDS))
            w_nr = 4'(MAX_ROUNDS);
        else
            w_nr = r_round_count;
    end

    // any block still in flight
    always_comb begin
        w_busy = 1'b0;
        for (int s = 0; s < NR; s++)
            w_busy = w_busy | v_valid[s];
    end

    // hold a key load until in-flight blocks have read their keys
    assign w_key_wait = i_valid && (i_mode == MODE_LOAD) && (32'(i_key_slot) < SLOTS)
                        && w_busy;

    assign w_en     = !o_valid || i_ready;
    assign o_ready  = w_en && !w_key_wait;
    assign w_cipher = (i_mode == MODE_ENC) || (i_mode == MODE_DEC);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_round_count <= 4'(MIN_ROUNDS);
        else if (i_cfg_we)
            r_round_count <= i_cfg_data;
    end

    // load key halves
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_mode == MODE_LOAD && 32'(i_key_slot) < SLOTS)
            r_keys[i_key_slot] <= i_key_half;
    end

    // key for a pipeline position: enc uses round p, dec round nr-p
    function automatic t_block key_of(input int p, input logic dec, input logic [3:0] nr);
        int rd;
        rd = dec ? (int'(nr) - p) : p;
        if (rd < 0) rd = 0;
        key_of = {r_keys[5'(2*rd)], r_keys[5'(2*rd + 1)]};
    endfunction

    // entry stage: initial key add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            v_valid[0] <= 1'b0;
        else if (w_en)
            v_valid[0] <= i_valid && w_cipher;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            v_dec[0]   <= (i_mode == MODE_DEC);
            v_state[0] <= {i_data_high, i_data_low}
                        ^ key_of(0, i_mode == MODE_DEC, w_nr);
        end
    end

    // round stages
    for (genvar g = 1; g < NR; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (v_valid[g-1]),
            .i_dec   (v_dec[g-1]),
            .i_bypass(4'(g) > w_nr),
            .i_last  (4'(g) == w_nr),
            .i_state (v_state[g-1]),
            .i_key   (key_of(g, v_dec[g-1], w_nr)),
            .o_valid (v_valid[g]),
            .o_dec   (v_dec[g]),
            .o_state (v_state[g])
        );
    end

    assign o_valid       = v_valid[NR-1];
    assign o_was_decrypt = v_dec[NR-1];
    assign o_result_high = v_state[NR-1][127:64];
    assign o_result_low  = v_state[NR-1][63:0];

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_high))
        else $error("result changed while stalled");
    // key loads never create a valid block at the entry stage
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode == MODE_LOAD |=> !v_valid[0])
        else $error("key load entered the cipher pipeline");
    // ready only when the output side lets the pipeline move
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!o_valid || i_ready))
        else $error("ready mismatch");
endmodule
`default_nettype wire
